// ----- sv/ccpp_pkg.sv -----
// ----------------------------------------------------------------------------
// ccpp_pkg
// Shared types, codes and the tag layout table of the constant pool parser.
// ----------------------------------------------------------------------------
package ccpp_pkg;

   // parser phases
   localparam logic [1:0] PH_TAG  = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_TEXT = 2'd2;
   localparam logic [1:0] PH_HALT = 2'd3;

   // result kinds
   localparam logic [1:0] K_RECORD  = 2'd0;
   localparam logic [1:0] K_HEADER  = 2'd1;
   localparam logic [1:0] K_TEXT    = 2'd2;
   localparam logic [1:0] K_INVALID = 2'd3;

   // constant pool tags
   localparam logic [7:0] TAG_UTF8          = 8'd1;
   localparam logic [7:0] TAG_INTEGER       = 8'd3;
   localparam logic [7:0] TAG_FLOAT         = 8'd4;
   localparam logic [7:0] TAG_LONG          = 8'd5;
   localparam logic [7:0] TAG_DOUBLE        = 8'd6;
   localparam logic [7:0] TAG_CLASS         = 8'd7;
   localparam logic [7:0] TAG_STRING        = 8'd8;
   localparam logic [7:0] TAG_FIELDREF      = 8'd9;
   localparam logic [7:0] TAG_METHODREF     = 8'd10;
   localparam logic [7:0] TAG_IFMETHODREF   = 8'd11;
   localparam logic [7:0] TAG_NAMEANDTYPE   = 8'd12;
   localparam logic [7:0] TAG_METHODHANDLE  = 8'd15;
   localparam logic [7:0] TAG_METHODTYPE    = 8'd16;
   localparam logic [7:0] TAG_INVOKEDYNAMIC = 8'd18;

   // body layout of a tag
   typedef struct packed {
      logic       known;
      logic [2:0] first;   // bytes of the first field
      logic [3:0] total;   // total body bytes
   } shape_type;

   // one result transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tag;
      logic [31:0] field_a;
      logic [31:0] field_b;
      logic [7:0]  text_byte;
      logic        last;
   } result_type;

   function automatic shape_type tag_shape(input logic [7:0] tag);
      shape_type s;
      s = '{known: 1'b0, first: 3'd0, total: 4'd0};
      unique case (tag)
         TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE:
            s = '{known: 1'b1, first: 3'd2, total: 4'd2};
         TAG_INTEGER, TAG_FLOAT:
            s = '{known: 1'b1, first: 3'd4, total: 4'd4};
         TAG_LONG, TAG_DOUBLE:
            s = '{known: 1'b1, first: 3'd4, total: 4'd8};
         TAG_FIELDREF, TAG_METHODREF, TAG_IFMETHODREF, TAG_NAMEANDTYPE,
         TAG_INVOKEDYNAMIC:
            s = '{known: 1'b1, first: 3'd2, total: 4'd4};
         TAG_METHODHANDLE:
            s = '{known: 1'b1, first: 3'd1, total: 4'd3};
         default:
            s = '{known: 1'b0, first: 3'd0, total: 4'd0};
      endcase
      return s;
   endfunction

endpackage

// ----- sv/ccpp_parser.sv -----
// ----------------------------------------------------------------------------
// ccpp_parser
// Entry state machine: consumes one byte per step, gathers entry bodies and
// produces at most one result per step.
// ----------------------------------------------------------------------------
module ccpp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            in_byte,
   input  logic                  pool_start,
   output logic                  res_valid,
   output ccpp_pkg::result_type  res
);

   logic [1:0]  phase_ff,    phase_in;
   logic [7:0]  tag_ff,      tag_in;
   logic [15:0] left_ff,     left_in;
   logic [31:0] first_ff,    first_in;
   logic [31:0] second_ff,   second_in;
   logic [3:0]  pos_ff,      pos_in;

   logic [1:0]           phase_eff;
   ccpp_pkg::shape_type  new_shape;
   ccpp_pkg::shape_type  cur_shape;
   logic [3:0]           pos_next;
   logic [31:0]          first_next;
   logic [31:0]          second_next;
   logic [15:0]          left_next;

   // a pool start forces tag parsing
   assign phase_eff = pool_start ? ccpp_pkg::PH_TAG : phase_ff;
   assign new_shape = ccpp_pkg::tag_shape(in_byte);
   assign cur_shape = ccpp_pkg::tag_shape(tag_ff);

   // body accumulation
   assign pos_next  = pos_ff + 4'd1;
   assign left_next = left_ff - 16'd1;
   always_comb begin
      first_next  = first_ff;
      second_next = second_ff;
      if (pos_ff < {1'b0, cur_shape.first}) begin
         first_next = {first_ff[23:0], in_byte};
      end else begin
         second_next = {second_ff[23:0], in_byte};
      end
   end

   // next state and result
   always_comb begin
      phase_in  = phase_ff;
      tag_in    = tag_ff;
      left_in   = left_ff;
      first_in  = first_ff;
      second_in = second_ff;
      pos_in    = pos_ff;
      res_valid = 1'b0;
      res       = '{kind: ccpp_pkg::K_RECORD, tag: tag_ff, field_a: 32'd0,
                    field_b: 32'd0, text_byte: 8'd0, last: 1'b1};
      if (step) begin
         unique case (phase_eff)
            ccpp_pkg::PH_TAG: begin
               tag_in    = in_byte;
               first_in  = 32'd0;
               second_in = 32'd0;
               pos_in    = 4'd0;
               left_in   = 16'd0;
               if (new_shape.known) begin
                  phase_in = ccpp_pkg::PH_BODY;
               end else begin
                  phase_in  = ccpp_pkg::PH_HALT;
                  res_valid = 1'b1;
                  res.kind  = ccpp_pkg::K_INVALID;
                  res.tag   = in_byte;
               end
            end
            ccpp_pkg::PH_TEXT: begin
               left_in = left_next;
               if (left_next == 16'd0) begin
                  phase_in = ccpp_pkg::PH_TAG;
               end
               res_valid     = 1'b1;
               res.kind      = ccpp_pkg::K_TEXT;
               res.text_byte = in_byte;
               res.last      = (left_next == 16'd0);
            end
            ccpp_pkg::PH_BODY: begin
               first_in  = first_next;
               second_in = second_next;
               pos_in    = pos_next;
               if (pos_next >= cur_shape.total) begin
                  pos_in    = 4'd0;
                  res_valid = 1'b1;
                  if (tag_ff == ccpp_pkg::TAG_UTF8) begin
                     left_in     = first_next[15:0];
                     phase_in    = (first_next[15:0] == 16'd0) ?
                                   ccpp_pkg::PH_TAG : ccpp_pkg::PH_TEXT;
                     res.kind    = ccpp_pkg::K_HEADER;
                     res.field_a = {16'd0, first_next[15:0]};
                     res.last    = (first_next[15:0] == 16'd0);
                  end else begin
                     phase_in    = ccpp_pkg::PH_TAG;
                     res.field_a = first_next;
                     res.field_b = second_next;
                  end
               end
            end
            ccpp_pkg::PH_HALT: begin
               // bytes dropped until the next pool start
            end
            default: begin
               phase_in = ccpp_pkg::PH_TAG;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ccpp_pkg::PH_TAG;
         tag_ff    <= 8'd0;
         left_ff   <= 16'd0;
         first_ff  <= 32'd0;
         second_ff <= 32'd0;
         pos_ff    <= 4'd0;
      end else begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         left_ff   <= left_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         pos_ff    <= pos_in;
      end
   end

   // a halted parser stays silent
   assert property (@(posedge clock) disable iff (reset)
      (step && !pool_start && phase_ff == ccpp_pkg::PH_HALT) |-> !res_valid)
      else $error("result produced while halted");

   // an invalid tag always halts the parser
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == ccpp_pkg::K_INVALID) |=>
      phase_ff == ccpp_pkg::PH_HALT)
      else $error("invalid tag did not halt");

   // text phase always has bytes outstanding
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ccpp_pkg::PH_TEXT) |-> (left_ff != 16'd0))
      else $error("text phase with no bytes left");

endmodule

// ----- sv/ccpp_out_reg.sv -----
// ----------------------------------------------------------------------------
// ccpp_out_reg
// Result register: holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module ccpp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ccpp_pkg::result_type  load_data,
   input  logic                  take_stall,
   output logic                  ready,
   output logic                  valid,
   output ccpp_pkg::result_type  data
);

   logic                  valid_ff, valid_in;
   ccpp_pkg::result_type  data_ff;

   // free when empty or being taken this cycle
   assign ready = !valid_ff || !take_stall;

   always_comb begin
      valid_in = valid_ff;
      if (ready) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ready && load) begin
         data_ff <= load_data;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

// ----- sv/classfile_constant_pool_parser.sv -----
// ----------------------------------------------------------------------------
// classfile_constant_pool_parser
// A byte accepted into the input register is stepped through the parser, and
// its result is loaded into the result register before it is offered.
// Throughput: one byte per cycle, limited only by rsp_stall.
// One input register, one parser step, one result register.
// Reset: parser back to expecting a tag, all accumulators and valids cleared.
// Streaming parser of class file constant pool entries, one byte a transaction.
// ----------------------------------------------------------------------------
module classfile_constant_pool_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_pool_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_entry_tag,
   output logic [31:0] rsp_field_a,
   output logic [31:0] rsp_field_b,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_last_of_entry
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_start_ff;
   logic                  out_ready;
   logic                  advance;
   logic                  accept;
   logic                  res_valid;
   ccpp_pkg::result_type  res;
   ccpp_pkg::result_type  out_data;

   // input register handshake
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_in_byte;
         in_start_ff <= req_pool_start;
      end
   end

   // parser step
   ccpp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (in_byte_ff),
      .pool_start (in_start_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result register
   ccpp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res_valid),
      .load_data  (res),
      .take_stall (rsp_stall),
      .ready      (out_ready),
      .valid      (rsp_valid),
      .data       (out_data)
   );

   assign rsp_result_kind   = out_data.kind;
   assign rsp_entry_tag     = out_data.tag;
   assign rsp_field_a       = out_data.field_a;
   assign rsp_field_b       = out_data.field_b;
   assign rsp_text_byte     = out_data.text_byte;
   assign rsp_last_of_entry = out_data.last;

endmodule

// ----- tb/sv/classfile_constant_pool_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// classfile_constant_pool_parser_tb
// Streams constant pool bytes into the parser and checks every result
// transaction, field by field, against a cycle-free model of the parser kept
// here. Covers all tags, unknown tags with halt, restarts, empty and long utf8
// entries, random idling on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------
module classfile_constant_pool_parser_tb;

   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int RANDOM_BYTES   = 500;

   // body layout of one tag: bytes of the first field and of the whole body
   typedef struct packed {
      logic       known;
      logic [3:0] lead;
      logic [3:0] span;
   } body_shape_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_pool_start;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_entry_tag;
   logic [31:0] rsp_field_a;
   logic [31:0] rsp_field_b;
   logic [7:0]  rsp_text_byte;
   logic        rsp_last_of_entry;

   // parser model state
   logic [1:0]  parse_phase;
   logic [7:0]  cur_tag;
   logic [15:0] text_left;
   logic [31:0] word_a;
   logic [31:0] word_b;
   logic [3:0]  body_count;

   ccpp_pkg::result_type  pending_results[$];

   // run control and tallies
   bit          sender_idle_on   = 1'b1;
   bit          receiver_idle_on = 1'b1;
   bit          hold_request     = 1'b0;
   int          hold_count       = 0;
   int          quiet_cycles     = 0;
   int          errors           = 0;
   int          bytes_accepted   = 0;
   int          kind_seen[4]     = '{0, 0, 0, 0};

   classfile_constant_pool_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_pool_start    (req_pool_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_entry_tag     (rsp_entry_tag),
      .rsp_field_a       (rsp_field_a),
      .rsp_field_b       (rsp_field_b),
      .rsp_text_byte     (rsp_text_byte),
      .rsp_last_of_entry (rsp_last_of_entry)
   );

   always #1 clock = ~clock;

   // body layout per tag, unknown tags flagged
   function automatic body_shape_type entry_layout(input logic [7:0] tag);
      body_shape_type s;
      s = '{known: 1'b1, lead: 4'd2, span: 4'd4};
      unique case (tag)
         ccpp_pkg::TAG_UTF8, ccpp_pkg::TAG_CLASS, ccpp_pkg::TAG_STRING,
         ccpp_pkg::TAG_METHODTYPE: s.span = 4'd2;
         ccpp_pkg::TAG_INTEGER, ccpp_pkg::TAG_FLOAT: begin
            s.lead = 4'd4;
            s.span = 4'd4;
         end
         ccpp_pkg::TAG_LONG, ccpp_pkg::TAG_DOUBLE: begin
            s.lead = 4'd4;
            s.span = 4'd8;
         end
         ccpp_pkg::TAG_FIELDREF, ccpp_pkg::TAG_METHODREF, ccpp_pkg::TAG_IFMETHODREF,
         ccpp_pkg::TAG_NAMEANDTYPE, ccpp_pkg::TAG_INVOKEDYNAMIC: s.span = 4'd4;
         ccpp_pkg::TAG_METHODHANDLE: begin
            s.lead = 4'd1;
            s.span = 4'd3;
         end
         default: s = '{known: 1'b0, lead: 4'd0, span: 4'd0};
      endcase
      return s;
   endfunction

   function automatic void push_result(input logic [1:0] kind, input logic [7:0] tag,
                                       input logic [31:0] a, input logic [31:0] b,
                                       input logic [7:0] text, input logic last);
      ccpp_pkg::result_type r;
      r.kind      = kind;
      r.tag       = tag;
      r.field_a   = a;
      r.field_b   = b;
      r.text_byte = text;
      r.last      = last;
      pending_results.push_back(r);
   endfunction

   // advance the parser model by one accepted byte
   function automatic void parse_byte(input logic [7:0] value, input logic start);
      body_shape_type lay;
      logic [15:0]    len;
      bytes_accepted++;
      if (start)
         parse_phase = ccpp_pkg::PH_TAG;
      case (parse_phase)
         ccpp_pkg::PH_TAG: begin
            cur_tag    = value;
            word_a     = '0;
            word_b     = '0;
            body_count = '0;
            text_left  = '0;
            lay        = entry_layout(value);
            if (!lay.known) begin
               parse_phase = ccpp_pkg::PH_HALT;
               push_result(ccpp_pkg::K_INVALID, value, '0, '0, '0, 1'b1);
            end else begin
               parse_phase = ccpp_pkg::PH_BODY;
            end
         end
         ccpp_pkg::PH_TEXT: begin
            text_left = text_left - 16'd1;
            if (text_left == 16'd0)
               parse_phase = ccpp_pkg::PH_TAG;
            push_result(ccpp_pkg::K_TEXT, cur_tag, '0, '0, value, text_left == 16'd0);
         end
         ccpp_pkg::PH_BODY: begin
            lay = entry_layout(cur_tag);
            if (body_count < lay.lead)
               word_a = {word_a[23:0], value};
            else
               word_b = {word_b[23:0], value};
            body_count = body_count + 4'd1;
            if (body_count >= lay.span) begin
               body_count = '0;
               if (cur_tag == ccpp_pkg::TAG_UTF8) begin
                  len         = word_a[15:0];
                  text_left   = len;
                  parse_phase = (len == 16'd0) ? ccpp_pkg::PH_TAG : ccpp_pkg::PH_TEXT;
                  push_result(ccpp_pkg::K_HEADER, cur_tag, {16'd0, len}, '0, '0,
                              len == 16'd0);
               end else begin
                  parse_phase = ccpp_pkg::PH_TAG;
                  push_result(ccpp_pkg::K_RECORD, cur_tag, word_a, word_b, '0, 1'b1);
               end
            end
         end
         default: ;  // halted: byte ignored
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      unique case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // send one byte; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] value, input logic start);
      while (sender_idle_on && $urandom_range(0, 99) < 25)
         @(negedge clock);
      req_valid      = 1'b1;
      req_in_byte    = value;
      req_pool_start = start;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      parse_byte(value, start);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // receiver: random stalls, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         rsp_stall  = 1'b1;
         hold_count = hold_count + 1;
         if (hold_count >= HOLD_CYCLES) begin
            hold_request = 1'b0;
            hold_count   = 0;
         end
      end else begin
         rsp_stall = receiver_idle_on && ($urandom_range(0, 99) < 25);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      ccpp_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: kind %0d tag 0x%0h",
                   rsp_result_kind, rsp_entry_tag);
            errors++;
         end else begin
            want = pending_results.pop_front();
            kind_seen[want.kind]++;
            check_field("result_kind", 32'(want.kind), 32'(rsp_result_kind));
            check_field("entry_tag", 32'(want.tag), 32'(rsp_entry_tag));
            check_field("field_a", want.field_a, rsp_field_a);
            check_field("field_b", want.field_b, rsp_field_b);
            check_field("text_byte", 32'(want.text_byte), 32'(rsp_text_byte));
            check_field("last_of_entry", 32'(want.last), 32'(rsp_last_of_entry));
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: timeout after %0d quiet cycles, %0d results outstanding",
                  quiet_cycles, pending_results.size());
         $display("tb: failure");
         $finish;
      end
   end

   // unknown tag, then bytes ignored until pool start, tag zero included
   task automatic test_invalid_tag();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h07, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // all-ones long entry fills both 32-bit fields
   task automatic test_wide_long();
      send_byte(ccpp_pkg::TAG_LONG, 1'b1);
      repeat (8) send_byte(8'hFF, 1'b0);
   endtask

   // zero-length utf8 gives only a header; then a one-byte string
   task automatic test_empty_utf8();
      send_byte(ccpp_pkg::TAG_UTF8, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(ccpp_pkg::TAG_UTF8, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
   endtask

   // pool start drops a partial method handle; full method handle after
   task automatic test_restart_mid_entry();
      send_byte(ccpp_pkg::TAG_METHODHANDLE, 1'b1);
      send_byte(8'h09, 1'b0);
      send_byte(ccpp_pkg::TAG_CLASS, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(ccpp_pkg::TAG_METHODHANDLE, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
   endtask

   // random pools: mostly whole entries, some unknown tags and cut entries
   task automatic test_random_pool(input int target);
      int             sent;
      int             pick;
      int             total;
      int             cut;
      int             i;
      bit             need_start;
      logic [7:0]     tag;
      logic [15:0]    len;
      body_shape_type lay;
      sent       = 0;
      need_start = 1'b1;
      while (sent < target) begin
         // a calm stretch with no idling on either side
         sender_idle_on   = !(sent >= target / 3 && sent < target / 2);
         receiver_idle_on = sender_idle_on;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            tag = 8'($urandom_range(0, 255));
            lay = entry_layout(tag);
            while (lay.known) begin
               tag = 8'($urandom_range(0, 255));
               lay = entry_layout(tag);
            end
            send_byte(tag, need_start || $urandom_range(0, 9) == 0);
            sent++;
            repeat ($urandom_range(0, 3)) send_byte(rand_byte(), 1'b0);
            need_start = 1'b1;
         end else begin
            tag = 8'($urandom_range(1, 18));
            lay = entry_layout(tag);
            while (!lay.known) begin
               tag = 8'($urandom_range(1, 18));
               lay = entry_layout(tag);
            end
            len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 60))
                                               : 16'($urandom_range(0, 12));
            total = lay.span + ((tag == ccpp_pkg::TAG_UTF8) ? int'(len) : 0);
            cut   = (pick >= 90) ? $urandom_range(0, total - 1) : total;
            send_byte(tag, need_start || $urandom_range(0, 9) == 0);
            sent++;
            for (i = 0; i < cut; i++) begin
               if (tag == ccpp_pkg::TAG_UTF8 && i == 0)
                  send_byte(len[15:8], 1'b0);
               else if (tag == ccpp_pkg::TAG_UTF8 && i == 1)
                  send_byte(len[7:0], 1'b0);
               else
                  send_byte(rand_byte(), 1'b0);
               sent++;
            end
            need_start = (cut < total);
         end
      end
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   // receiver holds off while a long string is offered, so the input stalls
   task automatic test_backpressure();
      int i;
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      send_byte(ccpp_pkg::TAG_UTF8, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'd40, 1'b0);
      for (i = 0; i < 40; i++)
         send_byte(rand_byte(), 1'b0);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = 8'h00;
      req_pool_start = 1'b0;
      parse_phase    = ccpp_pkg::PH_TAG;
      cur_tag        = '0;
      text_left      = '0;
      word_a         = '0;
      word_b         = '0;
      body_count     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_invalid_tag();
      test_wide_long();
      test_empty_utf8();
      test_restart_mid_entry();
      test_random_pool(RANDOM_BYTES);
      test_backpressure();

      // wait for every expected result, then let the pipeline settle
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb: %0d bytes parsed across all tags, unknown tags and restarts",
               bytes_accepted);
      $display("tb: checked %0d records, %0d utf8 headers, %0d text bytes, %0d invalid",
               kind_seen[ccpp_pkg::K_RECORD], kind_seen[ccpp_pkg::K_HEADER],
               kind_seen[ccpp_pkg::K_TEXT], kind_seen[ccpp_pkg::K_INVALID]);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/ccpp_pkg.sv
sv/ccpp_parser.sv
sv/ccpp_out_reg.sv
sv/classfile_constant_pool_parser.sv
tb/sv/classfile_constant_pool_parser_tb.sv
